// ===== rtl/core/tournament_branch_predictor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tournament branch predictor.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define TBP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tbp checker: property failed");

// Antecedent in one cycle, consequent starting in the next cycle.
`define TBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `TBP_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ===== rtl/core/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, table geometry, index and counter helpers for the
// tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // Table index widths; each table holds a power of two entries.
  localparam int LH_IDX_W = 10;
  localparam int LC_IDX_W = 10;
  localparam int GC_IDX_W = 12;
  localparam int CC_IDX_W = 12;

  localparam int LOCAL_HISTORY_ENTRIES  = 2 ** LH_IDX_W;
  localparam int LOCAL_COUNTER_ENTRIES  = 2 ** LC_IDX_W;
  localparam int GLOBAL_COUNTER_ENTRIES = 2 ** GC_IDX_W;
  localparam int CHOICE_COUNTER_ENTRIES = 2 ** CC_IDX_W;

  // Field and state widths.
  localparam int PC_W    = 32;
  localparam int LHIST_W = 10;
  localparam int PATH_W  = 12;
  localparam int LCNT_W  = 3;
  localparam int GCNT_W  = 2;

  // Keys are widened to this many bits before the index is cut out.
  localparam int IDX_KEY_W = 16;

  // The clearing sweep walks the largest table.
  localparam int CLR_W_A = (LH_IDX_W > LC_IDX_W) ? LH_IDX_W : LC_IDX_W;
  localparam int CLR_W_B = (GC_IDX_W > CC_IDX_W) ? GC_IDX_W : CC_IDX_W;
  localparam int CLR_W   = (CLR_W_A > CLR_W_B) ? CLR_W_A : CLR_W_B;

  // Reset contents of the tables.
  localparam logic [LHIST_W-1:0] LHIST_RST  = '0;
  localparam logic [LCNT_W-1:0]  LCNT_RST   = LCNT_W'(3);
  localparam logic [GCNT_W-1:0]  GCNT_RST   = GCNT_W'(1);
  localparam logic [GCNT_W-1:0]  CHOICE_RST = GCNT_W'(2);

  localparam logic [LCNT_W-1:0] LCNT_MAX = '1;
  localparam logic [GCNT_W-1:0] GCNT_MAX = '1;

  // Request kinds.
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CNT
  } tbp_state_e;

  // Read requests to the tables; the choice table reads with the global one.
  typedef struct packed {
    logic                lh_re;
    logic [LH_IDX_W-1:0] lh_addr;
    logic                lc_re;
    logic [LC_IDX_W-1:0] lc_addr;
    logic                gc_re;
    logic [GC_IDX_W-1:0] gc_addr;
    logic [CC_IDX_W-1:0] cc_addr;
  } tbp_rd_t;

  // Write requests to the tables.
  typedef struct packed {
    logic                lh_we;
    logic [LH_IDX_W-1:0] lh_addr;
    logic [LHIST_W-1:0]  lh_data;
    logic                lc_we;
    logic [LC_IDX_W-1:0] lc_addr;
    logic [LCNT_W-1:0]   lc_data;
    logic                gc_we;
    logic [GC_IDX_W-1:0] gc_addr;
    logic [GCNT_W-1:0]   gc_data;
    logic                cc_we;
    logic [CC_IDX_W-1:0] cc_addr;
    logic [GCNT_W-1:0]   cc_data;
  } tbp_wr_t;

  // Registered read data.
  typedef struct packed {
    logic [LHIST_W-1:0] lh;
    logic [LCNT_W-1:0]  lc;
    logic [GCNT_W-1:0]  gc;
    logic [GCNT_W-1:0]  cc;
  } tbp_rdata_t;

  // Result handed to the output register.
  typedef struct packed {
    logic valid;
    logic predicted_taken;
    logic used_global;
  } tbp_res_t;

  function automatic logic [LH_IDX_W-1:0] lh_index(input logic [LHIST_W-1:0] v);
    logic [IDX_KEY_W-1:0] k;
    k = IDX_KEY_W'(v);
    return k[LH_IDX_W-1:0];
  endfunction

  function automatic logic [LC_IDX_W-1:0] lc_index(input logic [LHIST_W-1:0] v);
    logic [IDX_KEY_W-1:0] k;
    k = IDX_KEY_W'(v);
    return k[LC_IDX_W-1:0];
  endfunction

  function automatic logic [GC_IDX_W-1:0] gc_index(input logic [PATH_W-1:0] v);
    logic [IDX_KEY_W-1:0] k;
    k = IDX_KEY_W'(v);
    return k[GC_IDX_W-1:0];
  endfunction

  function automatic logic [CC_IDX_W-1:0] cc_index(input logic [PATH_W-1:0] v);
    logic [IDX_KEY_W-1:0] k;
    k = IDX_KEY_W'(v);
    return k[CC_IDX_W-1:0];
  endfunction

  // Saturating step of a local counter.
  function automatic logic [LCNT_W-1:0] lcnt_move(input logic [LCNT_W-1:0] c,
                                                  input logic up);
    if (up) begin
      return (c == LCNT_MAX) ? c : LCNT_W'(c + 1'b1);
    end
    return (c == '0) ? c : LCNT_W'(c - 1'b1);
  endfunction

  // Saturating step of a global or choice counter.
  function automatic logic [GCNT_W-1:0] gcnt_move(input logic [GCNT_W-1:0] c,
                                                  input logic up);
    if (up) begin
      return (c == GCNT_MAX) ? c : GCNT_W'(c + 1'b1);
    end
    return (c == '0) ? c : GCNT_W'(c - 1'b1);
  endfunction

endpackage

// ===== rtl/core/tbp_if.sv =====
// ----------------------------------------------------------------------------
// tbp_if
// Valid/ready channels of the tournament branch predictor: request beats in,
// prediction beats out.
// ----------------------------------------------------------------------------
interface tbp_in_if import tbp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [PC_W-1:0] branch_pc;
  logic            cond_branch;
  logic            actual_taken;

  modport source (output valid, kind, branch_pc, cond_branch, actual_taken,
                  input ready);
  modport sink (input valid, kind, branch_pc, cond_branch, actual_taken,
                output ready);
endinterface

interface tbp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic used_global;

  modport source (output valid, predicted_taken, used_global, input ready);
  modport sink (input valid, predicted_taken, used_global, output ready);
endinterface

// ===== rtl/core/tbp_tables.sv =====
// ----------------------------------------------------------------------------
// tbp_tables
// The four predictor tables, each a synchronous memory with one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module tbp_tables import tbp_pkg::*; (
  input  logic       clk_i,
  input  tbp_rd_t    rd_i,
  input  tbp_wr_t    wr_i,
  output tbp_rdata_t rdata_o
);

  logic [LHIST_W-1:0] lh_mem [LOCAL_HISTORY_ENTRIES];
  logic [LCNT_W-1:0]  lc_mem [LOCAL_COUNTER_ENTRIES];
  logic [GCNT_W-1:0]  gc_mem [GLOBAL_COUNTER_ENTRIES];
  logic [GCNT_W-1:0]  cc_mem [CHOICE_COUNTER_ENTRIES];

  logic [LHIST_W-1:0] rd_lh_q;
  logic [LCNT_W-1:0]  rd_lc_q;
  logic [GCNT_W-1:0]  rd_gc_q;
  logic [GCNT_W-1:0]  rd_cc_q;

  // Local history table.
  always_ff @(posedge clk_i) begin
    if (wr_i.lh_we) begin
      lh_mem[wr_i.lh_addr] <= wr_i.lh_data;
    end
    if (rd_i.lh_re) begin
      rd_lh_q <= lh_mem[rd_i.lh_addr];
    end
  end

  // Local counter table.
  always_ff @(posedge clk_i) begin
    if (wr_i.lc_we) begin
      lc_mem[wr_i.lc_addr] <= wr_i.lc_data;
    end
    if (rd_i.lc_re) begin
      rd_lc_q <= lc_mem[rd_i.lc_addr];
    end
  end

  // Global counter table.
  always_ff @(posedge clk_i) begin
    if (wr_i.gc_we) begin
      gc_mem[wr_i.gc_addr] <= wr_i.gc_data;
    end
    if (rd_i.gc_re) begin
      rd_gc_q <= gc_mem[rd_i.gc_addr];
    end
  end

  // Choice counter table, read together with the global table.
  always_ff @(posedge clk_i) begin
    if (wr_i.cc_we) begin
      cc_mem[wr_i.cc_addr] <= wr_i.cc_data;
    end
    if (rd_i.gc_re) begin
      rd_cc_q <= cc_mem[rd_i.cc_addr];
    end
  end

  assign rdata_o = '{lh: rd_lh_q, lc: rd_lc_q, gc: rd_gc_q, cc: rd_cc_q};

endmodule

// ===== rtl/core/tbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbp_ctrl
// Sequencer of the predictor: clearing sweep after reset, table reads,
// prediction, training write-back and the path history register.
// ----------------------------------------------------------------------------
module tbp_ctrl import tbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbp_in_if.sink     in_i,
  input  logic       slot_free_i,
  input  tbp_rdata_t rdata_i,
  output tbp_rd_t    rd_o,
  output tbp_wr_t    wr_o,
  output tbp_res_t   res_o
);

  tbp_state_e state_q, state_d;
  logic [CLR_W-1:0]    clr_q, clr_d;
  logic [PATH_W-1:0]   path_q, path_d;
  logic                kind_q, cond_q, taken_q;
  logic [LH_IDX_W-1:0] lh_idx_q;

  logic accept;
  logic local_pred, global_pred, use_global, pred;
  logic g_ok, l_ok, train;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Prediction from the registered table reads.
  assign local_pred  = rdata_i.lc[LCNT_W-1];
  assign global_pred = rdata_i.gc[GCNT_W-1];
  assign use_global  = rdata_i.cc[GCNT_W-1];
  assign pred        = use_global ? global_pred : local_pred;
  assign g_ok        = (global_pred == taken_q);
  assign l_ok        = (local_pred == taken_q);
  assign train       = cond_q && (kind_q == KIND_UPDATE);

  // Next state, table requests and the result.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    path_d  = path_q;
    rd_o    = '0;
    wr_o    = '0;
    res_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_o.lh_we   = 1'b1;
        wr_o.lh_addr = clr_q[LH_IDX_W-1:0];
        wr_o.lh_data = LHIST_RST;
        wr_o.lc_we   = 1'b1;
        wr_o.lc_addr = clr_q[LC_IDX_W-1:0];
        wr_o.lc_data = LCNT_RST;
        wr_o.gc_we   = 1'b1;
        wr_o.gc_addr = clr_q[GC_IDX_W-1:0];
        wr_o.gc_data = GCNT_RST;
        wr_o.cc_we   = 1'b1;
        wr_o.cc_addr = clr_q[CC_IDX_W-1:0];
        wr_o.cc_data = CHOICE_RST;
        clr_d        = CLR_W'(clr_q + 1'b1);
        if (clr_q == {CLR_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_o.lh_re   = 1'b1;
          rd_o.lh_addr = lh_index(in_i.branch_pc[LHIST_W-1:0]);
          rd_o.gc_re   = 1'b1;
          rd_o.gc_addr = gc_index(path_q);
          rd_o.cc_addr = cc_index(path_q);
          state_d      = ST_HIST;
        end
      end
      ST_HIST: begin
        // The local history is in hand; fetch the counter it selects.
        rd_o.lc_re   = 1'b1;
        rd_o.lc_addr = lc_index(rdata_i.lh);
        state_d      = ST_CNT;
      end
      ST_CNT: begin
        if (slot_free_i) begin
          res_o.valid           = 1'b1;
          res_o.predicted_taken = cond_q ? pred : 1'b1;
          res_o.used_global     = cond_q ? use_global : 1'b0;
          if (train) begin
            wr_o.lh_we   = 1'b1;
            wr_o.lh_addr = lh_idx_q;
            wr_o.lh_data = {rdata_i.lh[LHIST_W-2:0], taken_q};
            wr_o.lc_we   = 1'b1;
            wr_o.lc_addr = lc_index(rdata_i.lh);
            wr_o.lc_data = lcnt_move(rdata_i.lc, taken_q);
            wr_o.gc_we   = 1'b1;
            wr_o.gc_addr = gc_index(path_q);
            wr_o.gc_data = gcnt_move(rdata_i.gc, taken_q);
            // The choice moves only when exactly one side was right.
            wr_o.cc_we   = (g_ok != l_ok);
            wr_o.cc_addr = cc_index(path_q);
            wr_o.cc_data = gcnt_move(rdata_i.cc, g_ok);
            path_d       = {path_q[PATH_W-2:0], taken_q};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      path_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      path_q  <= path_d;
    end
  end

  // Request fields held for the duration of the item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= in_i.kind;
      cond_q   <= in_i.cond_branch;
      taken_q  <= in_i.actual_taken;
      lh_idx_q <= lh_index(in_i.branch_pc[LHIST_W-1:0]);
    end
  end

endmodule

// ===== rtl/core/tournament_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Tournament conditional-branch direction predictor: local history with
// 3-bit counters, path-indexed 2-bit global and choice counters.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake    | Beat contents
//  in_i    | in  | valid/ready  | kind, branch_pc, cond_branch, actual_taken
//  out_o   | out | valid/ready  | predicted_taken, used_global
//
//  An item runs through ST_IDLE (accept with history, global and choice reads),
//  then ST_HIST (local counter read) and ST_CNT (prediction and write-back).
//  Two dependent reads (history, then the counter it selects) set this order.
//  After reset a clearing sweep of the largest table loads the reset values;
//  no request is accepted during the sweep.
//  A result that cannot enter the full output register holds the item.
// ----------------------------------------------------------------------------
module tournament_branch_predictor import tbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  tbp_in_if.sink   in_i,
  tbp_out_if.source out_o
);

  tbp_rd_t    rd;
  tbp_wr_t    wr;
  tbp_rdata_t rdata;
  tbp_res_t   res;

  logic out_valid_q, out_valid_d;
  logic out_pt_q, out_ug_q;
  logic slot_free;

  tbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .slot_free_i (slot_free),
    .rdata_i     (rdata),
    .rd_o        (rd),
    .wr_o        (wr),
    .res_o       (res)
  );

  tbp_tables u_tables (
    .clk_i   (clk_i),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rdata)
  );

  // Output register: free when empty or being drained this cycle.
  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_valid_d = res.valid ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_pt_q <= res.predicted_taken;
      out_ug_q <= res.used_global;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.predicted_taken = out_pt_q;
  assign out_o.used_global     = out_ug_q;

endmodule

// ===== rtl/core/tbp_checker.sv =====
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the tournament branch predictor, bound to the top.
// ----------------------------------------------------------------------------
`include "tournament_branch_predictor_macros.svh"

module tbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_predicted_taken_i,
  input logic out_used_global_i
);

  // A stalled result beat stays offered.
  `TBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled result beat keeps its contents.
  `TBP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_predicted_taken_i) && $stable(out_used_global_i))

  // One item at a time: no request is taken while its reads are in flight.
  `TBP_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i ##1 !in_ready_i)

  // The clearing sweep keeps requests out right after reset.
  `TBP_ASSERT(a_clear_after_reset, clk_i, rst_ni, !$past(rst_ni) |-> !in_ready_i)

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_predicted_taken_i (out_o.predicted_taken),
  .out_used_global_i     (out_o.used_global)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tournament branch predictor. A short table of
// directed request beats is followed by random traffic. The random traffic is
// mostly loop-shaped branch streams from a small address pool, with some noise.
// Each result beat is checked against its directed row's typed result, if any,
// else an in-bench model of the local, global and choice tables. Both channels
// idle at random; the result side once holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_top import tbp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS    = 1876;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int HOLD_OFF_AT     = 700;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int POOL_SIZE       = 12;

  // Thresholds at which a counter votes taken or selects the global side.
  localparam logic [LCNT_W-1:0] LCNT_TAKEN_MIN = LCNT_W'(4);
  localparam logic [GCNT_W-1:0] GCNT_TAKEN_MIN = GCNT_W'(2);

  typedef struct packed {
    logic            kind;
    logic [PC_W-1:0] pc;
    logic            cond;
    logic            taken;
    logic            checked;    // Expected result is typed into the row.
    logic            exp_taken;
    logic            exp_global;
  } branch_req_t;

  typedef struct packed {
    logic predicted_taken;
    logic used_global;
  } prediction_t;

  localparam int DIRECTED_ROWS = 24;

  // Directed beats: reset state, address extremes, both kinds, non-conditional
  // branches, a full path history of taken outcomes, and ignored outcomes on
  // predict beats.
  localparam branch_req_t DIRECTED[DIRECTED_ROWS] = '{
    '{KIND_PREDICT, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1},
    '{KIND_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{KIND_UPDATE,  32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
    '{KIND_UPDATE,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{KIND_PREDICT, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'h8000_03FF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'h7FFF_FC00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'h0000_0155, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{KIND_UPDATE,  32'h5555_5555, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{KIND_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  tbp_in_if  req_bus ();
  tbp_out_if pred_bus ();

  tournament_branch_predictor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (pred_bus)
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the predictor tables.
  logic [LHIST_W-1:0] local_hist_tbl [LOCAL_HISTORY_ENTRIES];
  logic [LCNT_W-1:0]  local_cnt_tbl  [LOCAL_COUNTER_ENTRIES];
  logic [GCNT_W-1:0]  global_cnt_tbl [GLOBAL_COUNTER_ENTRIES];
  logic [GCNT_W-1:0]  choice_cnt_tbl [CHOICE_COUNTER_ENTRIES];
  logic [PATH_W-1:0]  path_hist;

  branch_req_t pending_reqs[$];
  prediction_t expected_predictions[$];

  int errors;
  int beats_in;
  int beats_out;
  int predict_beats;
  int update_beats;
  int uncond_beats;
  int global_picks;
  int update_misses;
  int cycles;

  // Saturating up/down step of a counter that tops out at top.
  function automatic int sat_step(input int c, input logic up, input int top);
    if (up) begin
      return (c < top) ? c + 1 : c;
    end
    return (c > 0) ? c - 1 : c;
  endfunction

  // Looks up the direction for one beat and, for a conditional update, trains
  // the choice and direction counters and shifts the outcome into both
  // histories.
  function automatic prediction_t predict_and_train(input logic kind,
                                                    input logic [PC_W-1:0] pc,
                                                    input logic cond,
                                                    input logic taken);
    prediction_t p;
    logic [LHIST_W-1:0] hist_idx;
    logic [LHIST_W-1:0] hist;
    logic local_vote;
    logic global_vote;
    logic global_ok;
    logic local_ok;

    if (!cond) begin
      p.predicted_taken = 1'b1;
      p.used_global = 1'b0;
      return p;
    end

    hist_idx = pc[LHIST_W-1:0];
    hist = local_hist_tbl[hist_idx];
    local_vote = local_cnt_tbl[hist] >= LCNT_TAKEN_MIN;
    global_vote = global_cnt_tbl[path_hist] >= GCNT_TAKEN_MIN;
    p.used_global = choice_cnt_tbl[path_hist] >= GCNT_TAKEN_MIN;
    p.predicted_taken = p.used_global ? global_vote : local_vote;

    if (kind == KIND_UPDATE) begin
      global_ok = (global_vote == taken);
      local_ok = (local_vote == taken);
      // The chooser moves only when exactly one side got it right.
      if (global_ok != local_ok) begin
        choice_cnt_tbl[path_hist] =
          GCNT_W'(sat_step(choice_cnt_tbl[path_hist], global_ok, 3));
      end
      global_cnt_tbl[path_hist] = GCNT_W'(sat_step(global_cnt_tbl[path_hist], taken, 3));
      local_cnt_tbl[hist] = LCNT_W'(sat_step(local_cnt_tbl[hist], taken, 7));
      path_hist = {path_hist[PATH_W-2:0], taken};
      local_hist_tbl[hist_idx] = {hist[LHIST_W-2:0], taken};
    end
    return p;
  endfunction

  // Offers one request beat; returns at the first later edge with ready high.
  task automatic drive_req(input branch_req_t r);
    pending_reqs.push_back(r);
    req_bus.valid          <= 1'b1;
    req_bus.kind           <= r.kind;
    req_bus.branch_pc      <= r.pc;
    req_bus.cond_branch    <= r.cond;
    req_bus.actual_taken   <= r.taken;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Random gap on the request side: mostly none, sometimes short, rarely long.
  task automatic req_gap();
    int roll;
    int len;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      len = 0;
    end else if (roll < 90) begin
      len = $urandom_range(1, 3);
    end else if (roll < 98) begin
      len = $urandom_range(4, 10);
    end else begin
      len = $urandom_range(15, 40);
    end
    if (len > 0) begin
      req_bus.valid <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // Result-side ready: random stalls, stall-free stretches, one long hold-off.
  initial begin : result_ready_driver
    bit held;
    int roll;
    int len;
    held = 1'b0;
    pred_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      roll = $urandom_range(0, 99);
      if (!held && beats_in >= HOLD_OFF_AT) begin
        held = 1'b1;
        pred_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (roll < 55) begin
        pred_bus.ready <= 1'b1;
        len = (roll < 5) ? $urandom_range(60, 150) : $urandom_range(1, 12);
        repeat (len) @(posedge clk_i);
      end else begin
        pred_bus.ready <= 1'b0;
        len = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Checks result beats in order and predicts each accepted request beat.
  always @(posedge clk_i) begin : scoreboard
    prediction_t want;
    prediction_t got;
    branch_req_t row;
    if (rst_ni) begin
      if (pred_bus.valid && pred_bus.ready) begin
        beats_out++;
        got.predicted_taken = pred_bus.predicted_taken;
        got.used_global = pred_bus.used_global;
        if (expected_predictions.size() == 0) begin
          errors++;
          $display("[%0t] result beat with nothing expected: taken %0b global %0b",
                   $time, got.predicted_taken, got.used_global);
        end else begin
          want = expected_predictions[0];
          expected_predictions.delete(0);
          if (got.predicted_taken !== want.predicted_taken) begin
            errors++;
            $display("[%0t] beat %0d predicted_taken: expected %0b actual %0b",
                     $time, beats_out, want.predicted_taken, got.predicted_taken);
          end
          if (got.used_global !== want.used_global) begin
            errors++;
            $display("[%0t] beat %0d used_global: expected %0b actual %0b",
                     $time, beats_out, want.used_global, got.used_global);
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        beats_in++;
        row = pending_reqs[0];
        pending_reqs.delete(0);
        want = predict_and_train(req_bus.kind, req_bus.branch_pc,
                                 req_bus.cond_branch, req_bus.actual_taken);
        if (!req_bus.cond_branch) begin
          uncond_beats++;
        end else if (req_bus.kind == KIND_UPDATE) begin
          update_beats++;
          if (want.predicted_taken != req_bus.actual_taken) update_misses++;
        end else begin
          predict_beats++;
        end
        if (want.used_global) global_picks++;
        if (row.checked) begin
          want.predicted_taken = row.exp_taken;
          want.used_global = row.exp_global;
        end
        expected_predictions.push_back(want);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] run exceeded %0d cycles with %0d results outstanding",
               $time, CYCLE_LIMIT, expected_predictions.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Reset, stimulus and end of run.
  initial begin : stimulus
    logic [PC_W-1:0] pool_pc [POOL_SIZE];
    int pool_period [POOL_SIZE];
    int pool_trip [POOL_SIZE];
    branch_req_t r;
    int b;
    int roll;

    errors = 0;
    beats_in = 0;
    beats_out = 0;
    predict_beats = 0;
    update_beats = 0;
    uncond_beats = 0;
    global_picks = 0;
    update_misses = 0;
    cycles = 0;

    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_PREDICT;
    req_bus.branch_pc = '0;
    req_bus.cond_branch = 1'b0;
    req_bus.actual_taken = 1'b0;

    // Tables as they stand after the clearing sweep.
    for (int i = 0; i < LOCAL_HISTORY_ENTRIES; i++) local_hist_tbl[i] = '0;
    for (int i = 0; i < LOCAL_COUNTER_ENTRIES; i++) local_cnt_tbl[i] = LCNT_W'(3);
    for (int i = 0; i < GLOBAL_COUNTER_ENTRIES; i++) global_cnt_tbl[i] = GCNT_W'(1);
    for (int i = 0; i < CHOICE_COUNTER_ENTRIES; i++) choice_cnt_tbl[i] = GCNT_W'(2);
    path_hist = '0;

    // Pool of branches; period 0 marks a branch with random outcomes.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_pc[i] = $urandom();
      pool_period[i] = (i < 3) ? 0 : $urandom_range(2, 9);
      pool_trip[i] = 0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      drive_req(DIRECTED[i]);
      req_gap();
    end

    // Random traffic: loop-shaped streams from the pool, plus noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = '0;
      roll = $urandom_range(0, 99);
      r.kind = ($urandom_range(0, 99) < 78) ? KIND_UPDATE : KIND_PREDICT;
      r.cond = ($urandom_range(0, 99) < 90);
      if (roll < 18) begin
        r.pc = $urandom();
        r.taken = 1'($urandom_range(0, 1));
      end else begin
        b = $urandom_range(0, POOL_SIZE - 1);
        r.pc = pool_pc[b];
        if (pool_period[b] == 0) begin
          r.taken = ($urandom_range(0, 99) < 70);
        end else begin
          r.taken = (pool_trip[b] % pool_period[b]) != (pool_period[b] - 1);
          if (r.kind == KIND_UPDATE && r.cond) pool_trip[b]++;
          if ($urandom_range(0, 99) < 5) r.taken = ~r.taken;
        end
      end
      drive_req(r);
      req_gap();
    end
    req_bus.valid <= 1'b0;

    // Wait for one result beat per request beat sent.
    while (beats_out < DIRECTED_ROWS + RANDOM_ITEMS) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d request beats: %0d conditional predicts, %0d updates, %0d uncond.",
             beats_in, predict_beats, update_beats, uncond_beats);
    $display("Global side chosen %0d times; %0d updates were mispredicted; %0d errors.",
             global_picks, update_misses, errors);
    if (errors == 0 && expected_predictions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
